@@ sv/ffba_pkg.sv @@
// ============================================================================
// ffba_pkg
// Shared types, field widths and codes for the first-fit block allocator.
// ============================================================================
`default_nettype none

package ffba_pkg;

	// Field widths of the request and result transactions.
	localparam int REQ_TYPE_W = 2;
	localparam int LEN_W      = 13;
	localparam int HANDLE_W   = 6;
	localparam int OFF_W      = 12;
	localparam int WORD_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int START_W    = 12;

	// Default sizes of the descriptor table and the data memory.
	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int MEM_WORDS_DEF     = 4096;

	// Request type codes.
	localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREED      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OFFSET     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd5;

	// One request transaction.
	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [LEN_W-1:0]      alloc_len;
		logic [HANDLE_W-1:0]   handle;
		logic [OFF_W-1:0]      word_offset;
		logic [WORD_W-1:0]     write_data;
	} req_t;

	// One result transaction.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] out_handle;
		logic [START_W-1:0]  out_start;
		logic [LEN_W-1:0]    out_length;
		logic [WORD_W-1:0]   read_data;
	} res_t;

endpackage

`default_nettype wire

@@ sv/ffba_ram.sv @@
// ============================================================================
// ffba_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ============================================================================
`default_nettype none

module ffba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ sv/first_fit_block_allocator.sv @@
// ============================================================================
// first_fit_block_allocator
// First-fit allocator over a word memory, driven by a descriptor table kept
// in a synchronous RAM and scanned one descriptor per cycle.
// ============================================================================
// Sequence: a bad handle is answered straight from idle; free and write finish
// after the descriptor read; read adds a data-memory read; allocate scans the
// descriptors from 0 for the first freed one that fits, else it appends.
// Throughput: a new transaction is taken in the cycle its predecessor's result
// strobe is high; the receiver cannot stall and each result shows for one cycle.
// Reset clears the table count, bump pointer and control; memories are not cleared.
`default_nettype none

module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int MEM_WORDS     = MEM_WORDS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output res_t      res
);

	// Derived widths.
	localparam int TW   = $clog2(TABLE_ENTRIES);
	localparam int TOPW = TW + 1;
	localparam int AW   = $clog2(MEM_WORDS);
	localparam int BPW  = $clog2(MEM_WORDS + 1);
	localparam int HCW  = (TOPW > HANDLE_W) ? TOPW : HANDLE_W;
	localparam int LCW  = ((BPW > LEN_W) ? BPW : LEN_W) + 1;

	// Sequencer state codes.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_APPEND = 3'd2;
	localparam logic [2:0] S_DESC   = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;

	typedef struct packed {
		logic [BPW-1:0] start;
		logic [BPW-1:0] length;
		logic           freed;
	} desc_t;

	localparam int DW = $bits(desc_t);

	logic [2:0]      state_q, state_d;
	req_t            req_q;
	logic [TW-1:0]   scan_q, scan_d;
	logic [TOPW-1:0] top_q, top_d;
	logic [BPW-1:0]  bump_q, bump_d;
	logic            done_q, done_d;
	res_t            res_q, res_d;

	logic            desc_we;
	logic [TW-1:0]   desc_waddr;
	desc_t           desc_wdata;
	logic [TW-1:0]   desc_raddr;
	logic [DW-1:0]   desc_rbits;
	desc_t           desc_rd;

	logic            data_we;
	logic [AW-1:0]   data_addr;
	logic [WORD_W-1:0] data_rd;

	logic            accept;
	logic            in_bad;
	logic [LCW-1:0]  len_ext;
	logic [LCW-1:0]  dlen_ext;
	logic [LCW-1:0]  remain;
	logic [LCW-1:0]  addr_sum;
	logic            fits;
	logic            no_space;
	logic            full;
	logic            scan_last;
	logic [STATUS_W-1:0] acc_st;

	assign desc_rd = desc_t'(desc_rbits);

	// Descriptor table.
	ffba_ram #(
		.WIDTH(DW),
		.DEPTH(TABLE_ENTRIES)
	) u_desc_ram (
		.clk  (clk),
		.we   (desc_we),
		.waddr(desc_waddr),
		.wdata(desc_wdata),
		.raddr(desc_raddr),
		.rdata(desc_rbits)
	);

	// Data word memory.
	ffba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MEM_WORDS)
	) u_data_ram (
		.clk  (clk),
		.we   (data_we),
		.waddr(data_addr),
		.wdata(req_q.write_data),
		.raddr(data_addr),
		.rdata(data_rd)
	);

	// Checks on the incoming transaction and on the descriptor just read.
	always_comb begin
		accept    = start && (state_q == S_IDLE);
		in_bad    = !(HCW'(req.handle) < HCW'(top_q));
		len_ext   = LCW'(req_q.alloc_len);
		dlen_ext  = LCW'(desc_rd.length);
		fits      = desc_rd.freed && (len_ext <= dlen_ext);
		remain    = LCW'(MEM_WORDS) - LCW'(bump_q);
		no_space  = len_ext > remain;
		full      = (top_q == TOPW'(TABLE_ENTRIES));
		scan_last = ((TOPW'(scan_q) + TOPW'(1)) == top_q);
		addr_sum  = LCW'(desc_rd.start) + LCW'(req_q.word_offset);
		if (desc_rd.freed) begin
			acc_st = ST_FREED;
		end else if (LCW'(req_q.word_offset) >= dlen_ext) begin
			acc_st = ST_OFFSET;
		end else if (addr_sum >= LCW'(MEM_WORDS)) begin
			acc_st = ST_OFFSET;
		end else begin
			acc_st = ST_OK;
		end
		data_addr = AW'(addr_sum);
	end

	// Sequencer: search, append, descriptor read-modify-write and data access.
	always_comb begin
		state_d    = state_q;
		scan_d     = scan_q;
		top_d      = top_q;
		bump_d     = bump_q;
		done_d     = 1'b0;
		res_d      = res_q;
		desc_we    = 1'b0;
		desc_waddr = scan_q;
		desc_wdata = desc_rd;
		desc_raddr = scan_q + TW'(1);
		data_we    = 1'b0;
		case (state_q)
			S_IDLE: begin
				desc_raddr = (req.req_type == REQ_ALLOC) ? '0 : TW'(req.handle);
				if (accept) begin
					scan_d = '0;
					if (req.req_type == REQ_ALLOC) begin
						state_d = (top_q == '0) ? S_APPEND : S_SCAN;
					end else if (in_bad) begin
						done_d       = 1'b1;
						res_d        = '0;
						res_d.status = ST_BAD_HANDLE;
					end else begin
						state_d = S_DESC;
					end
				end
			end
			S_SCAN: begin
				if (fits) begin
					desc_we          = 1'b1;
					desc_wdata.freed = 1'b0;
					done_d           = 1'b1;
					res_d            = '0;
					res_d.status     = ST_OK;
					res_d.out_handle = HANDLE_W'(scan_q);
					res_d.out_start  = START_W'(desc_rd.start);
					res_d.out_length = LEN_W'(desc_rd.length);
					state_d          = S_IDLE;
				end else if (scan_last) begin
					state_d = S_APPEND;
				end else begin
					scan_d = scan_q + TW'(1);
				end
			end
			S_APPEND: begin
				done_d  = 1'b1;
				res_d   = '0;
				state_d = S_IDLE;
				if (no_space) begin
					res_d.status = ST_NO_SPACE;
				end else if (full) begin
					res_d.status = ST_TABLE_FULL;
				end else begin
					desc_we           = 1'b1;
					desc_waddr        = TW'(top_q);
					desc_wdata.start  = bump_q;
					desc_wdata.length = BPW'(req_q.alloc_len);
					desc_wdata.freed  = 1'b0;
					top_d             = top_q + TOPW'(1);
					bump_d            = bump_q + BPW'(req_q.alloc_len);
					res_d.status      = ST_OK;
					res_d.out_handle  = HANDLE_W'(top_q);
					res_d.out_start   = START_W'(bump_q);
					res_d.out_length  = req_q.alloc_len;
				end
			end
			S_DESC: begin
				desc_waddr = TW'(req_q.handle);
				res_d      = '0;
				if (req_q.req_type == REQ_FREE) begin
					desc_we          = 1'b1;
					desc_wdata.freed = 1'b1;
					done_d           = 1'b1;
					res_d.status     = ST_OK;
					state_d          = S_IDLE;
				end else if (req_q.req_type == REQ_WRITE) begin
					data_we      = (acc_st == ST_OK);
					done_d       = 1'b1;
					res_d.status = acc_st;
					state_d      = S_IDLE;
				end else if (acc_st == ST_OK) begin
					state_d = S_READ;
				end else begin
					done_d       = 1'b1;
					res_d.status = acc_st;
					state_d      = S_IDLE;
				end
			end
			S_READ: begin
				done_d          = 1'b1;
				res_d           = '0;
				res_d.status    = ST_OK;
				res_d.read_data = data_rd;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
			top_q   <= '0;
			bump_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
			top_q   <= top_d;
			bump_q  <= bump_d;
			done_q  <= done_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		res_q <= res_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire
